// ===== rtl/pph_pkg.sv =====
// ----------------------------------------------------------------------------
// pph_pkg
// Shared types, constants and byte tables of the PROXY header parser.
// ----------------------------------------------------------------------------
package pph_pkg;

  typedef enum logic [1:0] {
    ST_NONE       = 2'd0,
    ST_INCOMPLETE = 2'd1,
    ST_INVALID    = 2'd2,
    ST_SUCCESS    = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_SIG2  = 3'd1,
    PH_SIG1  = 3'd2,
    PH_V2    = 3'd3,
    PH_V1    = 3'd4,
    PH_V1_CR = 3'd5,
    PH_DONE  = 3'd6
  } phase_t;

  typedef enum logic [2:0] {
    FLD_FAMILY       = 3'd0,
    FLD_SRC          = 3'd1,
    FLD_DST          = 3'd2,
    FLD_PORT         = 3'd3,
    FLD_TAIL_ADDR    = 3'd4,
    FLD_TAIL_UNKNOWN = 3'd5,
    FLD_ERROR        = 3'd7
  } field_t;

  typedef enum logic [1:0] {
    ADDR_NONE = 2'd0,
    ADDR_V4   = 2'd1,
    ADDR_V6   = 2'd2
  } addr_kind_t;

  // Address text parser variables
  typedef struct packed {
    logic [7:0]  pos;
    logic [3:0]  groups;
    logic [3:0]  gap;
    logic [2:0]  xdig;
    logic [2:0]  octets;
    logic [2:0]  base;
    logic [15:0] val;
    logic [8:0]  dec;
    logic [7:0]  oct;
    logic        decok;
    logic        v4mode;
    logic        sawdig;
    logic        lead;
    logic        trail;
  } ip_t;

  localparam ip_t IP_RESET = '{pos: 8'd0, groups: 4'd0, gap: 4'd0, xdig: 3'd0,
                               octets: 3'd0, base: 3'd0, val: 16'd0, dec: 9'd0,
                               oct: 8'd0, decok: 1'b1, v4mode: 1'b0, sawdig: 1'b0,
                               lead: 1'b0, trail: 1'b0};

  typedef struct packed {
    status_t     status;
    logic        has_address;
    logic        is_ipv6;
    logic [63:0] addr_high;
    logic [63:0] addr_low;
    logic [15:0] source_port;
    logic [16:0] consumed;
  } result_t;

  localparam logic [7:0]  CH_SP    = 8'h20;
  localparam logic [7:0]  CH_CR    = 8'h0D;
  localparam logic [7:0]  CH_LF    = 8'h0A;
  localparam logic [7:0]  CH_COLON = 8'h3A;
  localparam logic [7:0]  CH_DOT   = 8'h2E;
  localparam logic [16:0] PORT_MAX = 17'd65535;
  localparam logic [16:0] PORT_SAT = 17'd65536;
  localparam logic [3:0]  V2_VERSION = 4'h2;
  localparam logic [3:0]  CMD_LOCAL  = 4'h0;
  localparam logic [3:0]  CMD_PROXY  = 4'h1;
  localparam logic [3:0]  FAM_INET   = 4'h1;
  localparam logic [3:0]  FAM_INET6  = 4'h2;
  localparam logic [15:0] V4_MIN_LEN = 16'd12;
  localparam logic [15:0] V6_MIN_LEN = 16'd36;
  localparam logic [16:0] V2_HDR_LEN = 17'd16;
  localparam logic [16:0] SIG2_LEN   = 17'd12;
  localparam logic [16:0] SIG1_LEN   = 17'd6;

  // 12-byte v2 signature
  function automatic logic [7:0] sig_v2_byte(input logic [3:0] idx);
    logic [7:0] b;
    case (idx)
      4'd0:    b = 8'h0D;
      4'd1:    b = 8'h0A;
      4'd2:    b = 8'h0D;
      4'd3:    b = 8'h0A;
      4'd4:    b = 8'h00;
      4'd5:    b = 8'h0D;
      4'd6:    b = 8'h0A;
      4'd7:    b = 8'h51;
      4'd8:    b = 8'h55;
      4'd9:    b = 8'h49;
      4'd10:   b = 8'h54;
      4'd11:   b = 8'h0A;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  // "PROXY "
  function automatic logic [7:0] lead_byte(input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0:    b = "P";
      3'd1:    b = "R";
      3'd2:    b = "O";
      3'd3:    b = "X";
      3'd4:    b = "Y";
      3'd5:    b = " ";
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  // Family words: 0 TCP4, 1 TCP6, 2 UNKNOWN
  function automatic logic [7:0] fam_byte(input logic [1:0] k, input logic [2:0] idx);
    logic [7:0] b;
    case ({k, idx})
      5'b00_000, 5'b01_000: b = "T";
      5'b00_001, 5'b01_001: b = "C";
      5'b00_010, 5'b01_010: b = "P";
      5'b00_011:            b = "4";
      5'b01_011:            b = "6";
      5'b10_000:            b = "U";
      5'b10_001:            b = "N";
      5'b10_010:            b = "K";
      5'b10_011:            b = "N";
      5'b10_100:            b = "O";
      5'b10_101:            b = "W";
      5'b10_110:            b = "N";
      default:              b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] fam_len(input logic [1:0] k);
    return (k == 2'd2) ? 8'd7 : 8'd4;
  endfunction

  // {valid, decimal, value}
  function automatic logic [5:0] hex_digit(input logic [7:0] c);
    logic [5:0] r;
    r = 6'd0;
    if (c >= "0" && c <= "9") r = {2'b11, 4'(c - "0")};
    else if (c >= "a" && c <= "f") r = {2'b10, 4'(c - "a" + 8'd10)};
    else if (c >= "A" && c <= "F") r = {2'b10, 4'(c - "A" + 8'd10)};
    return r;
  endfunction

  // Group and half of a dotted-quad octet: {group, high_byte}
  function automatic logic [3:0] octet_slot(input logic [2:0] octets, input logic [2:0] base);
    logic [1:0] k;
    logic [2:0] g;
    k = 2'(octets - 3'd1);
    g = base + {2'b00, k[1]};
    return {g, ~k[0]};
  endfunction

endpackage

// ===== rtl/pph_parser.sv =====
// ----------------------------------------------------------------------------
// pph_parser
// Per-byte parser state and the combinational update that yields a decision.
// ----------------------------------------------------------------------------
module pph_parser #(
  parameter int MAX_TEXT_LINE = 107
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             take,
  input  logic [7:0]       byte_value,
  input  logic             start_req,
  input  logic             buffer_end,
  output logic             emit,
  output pph_pkg::result_t result
);

  pph_pkg::phase_t phase, phase_next;
  logic [16:0]     byte_count, byte_count_next;
  logic [7:0]      ver_cmd, ver_cmd_next;
  logic [7:0]      v2_fam, v2_fam_next;
  logic [15:0]     v2_len, v2_len_next;
  logic [15:0]     groups [8];
  logic [15:0]     groups_next [8];
  pph_pkg::field_t fld, fld_next;
  logic [2:0]      fam_mask, fam_mask_next;
  pph_pkg::ip_t    ip, ip_next;
  logic [16:0]     port_acc, port_next;

  logic                 dec_emit;
  pph_pkg::status_t     dec_st;
  pph_pkg::addr_kind_t  dec_addr;
  logic [16:0]          dec_used;

  // Next state for one byte
  always_comb begin : next_state
    logic [7:0]  c;
    logic [16:0] i;
    logic        fail;
    logic [5:0]  hx;
    logic [11:0] nv;
    logic [11:0] nd;
    logic [19:0] pv;
    logic [3:0]  slot;
    logic [1:0]  pick;
    logic        pick_ok;
    logic [3:0]  g0;
    logic [3:0]  ncnt;
    logic [3:0]  off;
    logic [3:0]  src;
    logic [15:0] tmp [8];
    logic [3:0]  fm;
    logic [16:0] total;

    c = byte_value;
    i = '0;
    fail = 1'b0;
    hx = '0;
    nv = '0;
    nd = '0;
    pv = '0;
    slot = '0;
    pick = '0;
    pick_ok = 1'b0;
    g0 = '0;
    ncnt = '0;
    off = '0;
    src = '0;
    fm = '0;
    total = '0;

    phase_next      = phase;
    byte_count_next = byte_count;
    ver_cmd_next    = ver_cmd;
    v2_fam_next     = v2_fam;
    v2_len_next     = v2_len;
    for (int k = 0; k < 8; k++) groups_next[k] = groups[k];
    fld_next        = fld;
    fam_mask_next   = fam_mask;
    ip_next         = ip;
    port_next       = port_acc;

    // New connection clears everything first
    if (start_req) begin
      phase_next      = pph_pkg::PH_IDLE;
      byte_count_next = '0;
      ver_cmd_next    = '0;
      v2_fam_next     = '0;
      v2_len_next     = '0;
      for (int k = 0; k < 8; k++) groups_next[k] = '0;
      fld_next        = pph_pkg::FLD_FAMILY;
      fam_mask_next   = 3'b111;
      ip_next         = pph_pkg::IP_RESET;
      port_next       = '0;
    end

    for (int k = 0; k < 8; k++) tmp[k] = groups_next[k];

    dec_emit = 1'b0;
    dec_st   = pph_pkg::ST_NONE;
    dec_addr = pph_pkg::ADDR_NONE;
    dec_used = '0;

    if (phase_next != pph_pkg::PH_DONE) begin
      i = byte_count_next;
      byte_count_next = byte_count_next + 17'd1;
      fm = v2_fam_next[7:4];

      case (phase_next)
        pph_pkg::PH_IDLE: begin
          if (c == pph_pkg::sig_v2_byte(4'd0)) phase_next = pph_pkg::PH_SIG2;
          else if (c == pph_pkg::lead_byte(3'd0)) phase_next = pph_pkg::PH_SIG1;
          else begin
            dec_emit = 1'b1;
            dec_st   = pph_pkg::ST_NONE;
          end
        end

        pph_pkg::PH_SIG2: begin
          if (i >= pph_pkg::SIG2_LEN || c != pph_pkg::sig_v2_byte(i[3:0])) begin
            dec_emit = 1'b1;
            dec_st   = pph_pkg::ST_NONE;
          end else if (i == pph_pkg::SIG2_LEN - 17'd1) begin
            phase_next = pph_pkg::PH_V2;
          end
        end

        pph_pkg::PH_SIG1: begin
          if (i >= pph_pkg::SIG1_LEN || c != pph_pkg::lead_byte(i[2:0])) begin
            dec_emit = 1'b1;
            dec_st   = pph_pkg::ST_NONE;
          end else if (i == pph_pkg::SIG1_LEN - 17'd1) begin
            phase_next = pph_pkg::PH_V1;
            ip_next    = pph_pkg::IP_RESET;
          end
        end

        // Binary header: fixed fields, then address block
        pph_pkg::PH_V2: begin
          if (i == 17'd12) ver_cmd_next = c;
          else if (i == 17'd13) v2_fam_next = c;
          else if (i == 17'd14) v2_len_next[15:8] = c;
          else if (i == 17'd15) v2_len_next[7:0] = c;
          else begin
            if (i < 17'd32) begin
              if (!i[0]) groups_next[i[3:1]][15:8] = c;
              else groups_next[i[3:1]][7:0] = c;
            end
            if ((fm == pph_pkg::FAM_INET && i == 17'd24) ||
                (fm == pph_pkg::FAM_INET6 && i == 17'd48))
              port_next = {1'b0, c, 8'h00};
            if ((fm == pph_pkg::FAM_INET && i == 17'd25) ||
                (fm == pph_pkg::FAM_INET6 && i == 17'd49))
              port_next = {1'b0, port_next[15:8], c};
          end
          if (i >= 17'd15 &&
              ({1'b0, i} + 18'd1) == (18'd16 + {2'b00, v2_len_next})) begin
            total    = pph_pkg::V2_HDR_LEN + {1'b0, v2_len_next};
            fm       = v2_fam_next[7:4];
            dec_emit = 1'b1;
            if (ver_cmd_next[7:4] != pph_pkg::V2_VERSION) begin
              dec_st = pph_pkg::ST_INVALID;
            end else if (ver_cmd_next[3:0] == pph_pkg::CMD_LOCAL) begin
              dec_st   = pph_pkg::ST_SUCCESS;
              dec_used = total;
            end else if (ver_cmd_next[3:0] != pph_pkg::CMD_PROXY) begin
              dec_st = pph_pkg::ST_INVALID;
            end else if (fm == pph_pkg::FAM_INET) begin
              if (v2_len_next < pph_pkg::V4_MIN_LEN) begin
                dec_st = pph_pkg::ST_INVALID;
              end else begin
                groups_next[6] = groups_next[0];
                groups_next[7] = groups_next[1];
                dec_st   = pph_pkg::ST_SUCCESS;
                dec_addr = pph_pkg::ADDR_V4;
                dec_used = total;
              end
            end else if (fm == pph_pkg::FAM_INET6) begin
              if (v2_len_next < pph_pkg::V6_MIN_LEN) begin
                dec_st = pph_pkg::ST_INVALID;
              end else begin
                dec_st   = pph_pkg::ST_SUCCESS;
                dec_addr = pph_pkg::ADDR_V6;
                dec_used = total;
              end
            end else begin
              dec_st   = pph_pkg::ST_SUCCESS;
              dec_used = total;
            end
          end
        end

        // Text line
        pph_pkg::PH_V1, pph_pkg::PH_V1_CR: begin
          if (phase_next == pph_pkg::PH_V1_CR && c == pph_pkg::CH_LF) begin
            // Line end
            dec_emit = 1'b1;
            if (fld_next == pph_pkg::FLD_TAIL_UNKNOWN ||
                (fld_next == pph_pkg::FLD_FAMILY && fam_mask_next[2] &&
                 ip_next.pos == 8'd7)) begin
              dec_st   = pph_pkg::ST_SUCCESS;
              dec_used = byte_count_next;
            end else if (fld_next == pph_pkg::FLD_TAIL_ADDR) begin
              dec_st   = pph_pkg::ST_SUCCESS;
              dec_addr = (fam_mask_next == 3'b001) ? pph_pkg::ADDR_V4 : pph_pkg::ADDR_V6;
              dec_used = byte_count_next;
            end else begin
              dec_st = pph_pkg::ST_INVALID;
            end
          end else begin
            // A lone CR breaks any field that checks its characters
            if (phase_next == pph_pkg::PH_V1_CR) begin
              if (fld_next == pph_pkg::FLD_FAMILY || fld_next == pph_pkg::FLD_SRC ||
                  fld_next == pph_pkg::FLD_PORT)
                fld_next = pph_pkg::FLD_ERROR;
              phase_next = pph_pkg::PH_V1;
            end
            if (c == pph_pkg::CH_CR) begin
              phase_next = pph_pkg::PH_V1_CR;
            end else begin
              case (fld_next)
                pph_pkg::FLD_FAMILY: begin
                  if (c == pph_pkg::CH_SP) begin
                    for (int k = 0; k < 3; k++) begin
                      if (fam_mask_next[k] && ip_next.pos == pph_pkg::fam_len(2'(k))) begin
                        pick    = 2'(k);
                        pick_ok = 1'b1;
                      end
                    end
                    if (pick_ok && pick == 2'd2) begin
                      fld_next = pph_pkg::FLD_TAIL_UNKNOWN;
                    end else if (pick_ok) begin
                      fam_mask_next = 3'(3'b001 << pick);
                      fld_next      = pph_pkg::FLD_SRC;
                      for (int k = 0; k < 8; k++) groups_next[k] = '0;
                      ip_next      = pph_pkg::IP_RESET;
                      ip_next.base = (pick == 2'd0) ? 3'd6 : 3'd0;
                    end else begin
                      fail = 1'b1;
                    end
                  end else begin
                    for (int k = 0; k < 3; k++) begin
                      if (ip_next.pos >= pph_pkg::fam_len(2'(k)) ||
                          pph_pkg::fam_byte(2'(k), ip_next.pos[2:0]) != c)
                        fam_mask_next[k] = 1'b0;
                    end
                    if (ip_next.pos != 8'd255) ip_next.pos = ip_next.pos + 8'd1;
                  end
                end

                pph_pkg::FLD_SRC: begin
                  if (c == pph_pkg::CH_SP) begin
                    if (fam_mask_next == 3'b001) begin
                      // End of dotted quad
                      if (!ip_next.sawdig || ip_next.octets != 3'd4) fail = 1'b1;
                      else begin
                        slot = pph_pkg::octet_slot(ip_next.octets, ip_next.base);
                        if (slot[0]) groups_next[slot[3:1]][15:8] = ip_next.oct;
                        else groups_next[slot[3:1]][7:0] = ip_next.oct;
                      end
                    end else begin
                      // End of IPv6 text
                      if (ip_next.v4mode) begin
                        if (!ip_next.sawdig || ip_next.octets != 3'd4) fail = 1'b1;
                        else begin
                          slot = pph_pkg::octet_slot(ip_next.octets, ip_next.base);
                          if (slot[0]) groups_next[slot[3:1]][15:8] = ip_next.oct;
                          else groups_next[slot[3:1]][7:0] = ip_next.oct;
                        end
                        ip_next.groups = ip_next.groups + 4'd2;
                      end else begin
                        if (ip_next.lead && ip_next.pos < 8'd2) fail = 1'b1;
                        if (ip_next.trail) fail = 1'b1;
                        if (ip_next.xdig != 3'd0) begin
                          if (ip_next.groups >= 4'd8) fail = 1'b1;
                          else begin
                            groups_next[ip_next.groups[2:0]] = ip_next.val;
                            ip_next.groups = ip_next.groups + 4'd1;
                          end
                        end
                      end
                      // Expand the double colon
                      if (ip_next.gap != 4'd0) begin
                        g0 = ip_next.gap - 4'd1;
                        if (ip_next.groups >= 4'd8 || g0 > ip_next.groups) fail = 1'b1;
                        else begin
                          ncnt = ip_next.groups - g0;
                          off  = 4'd8 - ncnt;
                          for (int k = 0; k < 8; k++) tmp[k] = groups_next[k];
                          for (int k = 0; k < 8; k++) begin
                            if (4'(k) >= g0) begin
                              if (4'(k) < off) groups_next[k] = '0;
                              else begin
                                src = 4'(k) - off + g0;
                                groups_next[k] = tmp[src[2:0]];
                              end
                            end
                          end
                        end
                      end else if (ip_next.groups != 4'd8) begin
                        fail = 1'b1;
                      end
                    end
                    fld_next = pph_pkg::FLD_DST;
                  end else begin
                    if (fam_mask_next == 3'b001 || ip_next.v4mode) begin
                      // Dotted-quad character
                      if (c >= "0" && c <= "9") begin
                        nv = {4'd0, ip_next.oct} * 12'd10 + {4'd0, 8'(c - "0")};
                        if (ip_next.sawdig && ip_next.oct == 8'd0) fail = 1'b1;
                        else if (nv > 12'd255) fail = 1'b1;
                        else begin
                          ip_next.oct = nv[7:0];
                          if (!ip_next.sawdig) begin
                            if (ip_next.octets >= 3'd4) fail = 1'b1;
                            else begin
                              ip_next.octets = ip_next.octets + 3'd1;
                              ip_next.sawdig = 1'b1;
                            end
                          end
                        end
                      end else if (c == pph_pkg::CH_DOT && ip_next.sawdig) begin
                        if (ip_next.octets == 3'd4) fail = 1'b1;
                        else begin
                          slot = pph_pkg::octet_slot(ip_next.octets, ip_next.base);
                          if (slot[0]) groups_next[slot[3:1]][15:8] = ip_next.oct;
                          else groups_next[slot[3:1]][7:0] = ip_next.oct;
                          ip_next.oct    = '0;
                          ip_next.sawdig = 1'b0;
                        end
                      end else begin
                        fail = 1'b1;
                      end
                    end else begin
                      // IPv6 character
                      hx = pph_pkg::hex_digit(c);
                      if (ip_next.pos == 8'd0 && c == pph_pkg::CH_COLON) begin
                        ip_next.lead = 1'b1;
                      end else if (ip_next.pos == 8'd1 && ip_next.lead &&
                                   c != pph_pkg::CH_COLON) begin
                        fail = 1'b1;
                      end else begin
                        ip_next.trail = 1'b0;
                        if (hx[5]) begin
                          if (ip_next.xdig >= 3'd4) fail = 1'b1;
                          else begin
                            if (hx[4]) begin
                              nd = {3'd0, ip_next.dec} * 12'd10 + {8'd0, hx[3:0]};
                              if (ip_next.xdig != 3'd0 && ip_next.dec == 9'd0)
                                ip_next.decok = 1'b0;
                              if (nd > 12'd255) begin
                                ip_next.decok = 1'b0;
                                nd = 12'd256;
                              end
                              ip_next.dec = nd[8:0];
                            end else begin
                              ip_next.decok = 1'b0;
                            end
                            ip_next.val  = {ip_next.val[11:0], hx[3:0]};
                            ip_next.xdig = ip_next.xdig + 3'd1;
                          end
                        end else if (c == pph_pkg::CH_COLON) begin
                          if (ip_next.xdig == 3'd0) begin
                            if (ip_next.gap != 4'd0) fail = 1'b1;
                            else ip_next.gap = ip_next.groups + 4'd1;
                          end else begin
                            if (ip_next.groups >= 4'd8) fail = 1'b1;
                            else begin
                              groups_next[ip_next.groups[2:0]] = ip_next.val;
                              ip_next.groups = ip_next.groups + 4'd1;
                              ip_next.trail  = 1'b1;
                            end
                          end
                          ip_next.val   = '0;
                          ip_next.xdig  = '0;
                          ip_next.dec   = '0;
                          ip_next.decok = 1'b1;
                        end else if (c == pph_pkg::CH_DOT) begin
                          if (ip_next.groups > 4'd6 || ip_next.xdig == 3'd0 ||
                              !ip_next.decok) begin
                            fail = 1'b1;
                          end else begin
                            // Switch to an embedded dotted-quad tail
                            ip_next.v4mode = 1'b1;
                            ip_next.base   = ip_next.groups[2:0];
                            ip_next.octets = 3'd1;
                            groups_next[ip_next.groups[2:0]][15:8] = ip_next.dec[7:0];
                            ip_next.oct    = '0;
                            ip_next.sawdig = 1'b0;
                          end
                        end else begin
                          fail = 1'b1;
                        end
                      end
                    end
                    if (ip_next.pos != 8'd255) ip_next.pos = ip_next.pos + 8'd1;
                  end
                end

                pph_pkg::FLD_DST: begin
                  if (c == pph_pkg::CH_SP) begin
                    fld_next    = pph_pkg::FLD_PORT;
                    port_next   = '0;
                    ip_next.pos = '0;
                  end
                end

                pph_pkg::FLD_PORT: begin
                  if (c == pph_pkg::CH_SP) begin
                    if (ip_next.pos == 8'd0 || port_next > pph_pkg::PORT_MAX) fail = 1'b1;
                    else fld_next = pph_pkg::FLD_TAIL_ADDR;
                  end else if (c >= "0" && c <= "9") begin
                    pv = {3'd0, port_next} * 20'd10 + {12'd0, 8'(c - "0")};
                    if (pv > {3'd0, pph_pkg::PORT_SAT}) port_next = pph_pkg::PORT_SAT;
                    else port_next = pv[16:0];
                    ip_next.pos = 8'd1;
                  end else begin
                    fail = 1'b1;
                  end
                end

                default: ;
              endcase
              if (fail) fld_next = pph_pkg::FLD_ERROR;
            end
            // Line length bound
            if (byte_count_next >= 17'(MAX_TEXT_LINE)) begin
              dec_emit = 1'b1;
              dec_st   = pph_pkg::ST_INVALID;
            end
          end
        end

        default: ;
      endcase

      if (dec_emit) phase_next = pph_pkg::PH_DONE;
      else if (buffer_end) begin
        dec_emit = 1'b1;
        dec_st   = pph_pkg::ST_INCOMPLETE;
      end
    end
  end

  // Result formatting, IPv4-mapped IPv6 folded to IPv4
  always_comb begin : format
    logic                mapped;
    pph_pkg::addr_kind_t kind;
    mapped = (groups_next[5] == 16'hFFFF);
    for (int k = 0; k < 5; k++) if (groups_next[k] != 16'd0) mapped = 1'b0;
    kind = dec_addr;
    if (kind == pph_pkg::ADDR_V6 && mapped) kind = pph_pkg::ADDR_V4;
    result = '0;
    result.status      = dec_st;
    result.has_address = (kind != pph_pkg::ADDR_NONE);
    result.is_ipv6     = (kind == pph_pkg::ADDR_V6);
    if (kind == pph_pkg::ADDR_V6) begin
      result.addr_high = {groups_next[0], groups_next[1], groups_next[2], groups_next[3]};
      result.addr_low  = {groups_next[4], groups_next[5], groups_next[6], groups_next[7]};
    end else if (kind == pph_pkg::ADDR_V4) begin
      result.addr_low = {32'd0, groups_next[6], groups_next[7]};
    end
    if (kind != pph_pkg::ADDR_NONE) result.source_port = port_next[15:0];
    if (dec_st == pph_pkg::ST_SUCCESS) result.consumed = dec_used;
  end

  assign emit = take && dec_emit;

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= pph_pkg::PH_IDLE;
      byte_count <= '0;
      ver_cmd    <= '0;
      v2_fam     <= '0;
      v2_len     <= '0;
      for (int k = 0; k < 8; k++) groups[k] <= '0;
      fld        <= pph_pkg::FLD_FAMILY;
      fam_mask   <= 3'b111;
      ip         <= pph_pkg::IP_RESET;
      port_acc   <= '0;
    end else if (take) begin
      phase      <= phase_next;
      byte_count <= byte_count_next;
      ver_cmd    <= ver_cmd_next;
      v2_fam     <= v2_fam_next;
      v2_len     <= v2_len_next;
      for (int k = 0; k < 8; k++) groups[k] <= groups_next[k];
      fld        <= fld_next;
      fam_mask   <= fam_mask_next;
      ip         <= ip_next;
      port_acc   <= port_next;
    end
  end

endmodule

// ===== rtl/proxy_protocol_header_parser_core.sv =====
// ----------------------------------------------------------------------------
// proxy_protocol_header_parser_core
// PROXY protocol v1/v2 header detector and source address extractor.
// ----------------------------------------------------------------------------
//  channel | handshake          | payload
//  input   | in_valid/in_stall  | byte_value, start_req, buffer_end
//  output  | out_valid/out_stall| status, has_address, is_ipv6, addr_high,
//          |                    | addr_low, source_port, consumed
//
// One byte per cycle while the output is not stalled. A byte is held in the input
// register, parsed there combinationally, and its result (if any) is captured
// in the output register when the byte advances.
// Reset clears the input and output valid flags and the parser state.
// A stalled output holds its result; the input register then stalls too.
module proxy_protocol_header_parser_core #(
  parameter int MAX_TEXT_LINE = 107
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  byte_value,
  input  logic        start_req,
  input  logic        buffer_end,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic        has_address,
  output logic        is_ipv6,
  output logic [63:0] addr_high,
  output logic [63:0] addr_low,
  output logic [15:0] source_port,
  output logic [16:0] consumed
);

  logic             s_valid;
  logic [7:0]       s_byte;
  logic             s_start;
  logic             s_bend;
  logic             advance;
  logic             emit;
  pph_pkg::result_t result;
  pph_pkg::result_t res_q;

  // Parse the held byte when the output register can take a result
  assign advance  = s_valid && (!out_valid || !out_stall);
  assign in_stall = s_valid && !advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (!in_stall) begin
      s_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s_byte  <= byte_value;
      s_start <= start_req;
      s_bend  <= buffer_end;
    end
  end

  pph_parser #(
    .MAX_TEXT_LINE(MAX_TEXT_LINE)
  ) u_parser (
    .clk        (clk),
    .rst        (rst),
    .take       (advance),
    .byte_value (s_byte),
    .start_req  (s_start),
    .buffer_end (s_bend),
    .emit       (emit),
    .result     (result)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      out_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) res_q <= result;
  end

  assign status      = res_q.status;
  assign has_address = res_q.has_address;
  assign is_ipv6     = res_q.is_ipv6;
  assign addr_high   = res_q.addr_high;
  assign addr_low    = res_q.addr_low;
  assign source_port = res_q.source_port;
  assign consumed    = res_q.consumed;

endmodule
